// ===== rtl/core/ledser_pkg.sv =====
package ledser_pkg;

    // Store depth and the widths that follow from it.
    localparam int MAX_LEDS    = 256;
    localparam int ADDR_W      = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CNT_W       = $clog2(MAX_LEDS + 1);

    // Fixed field widths.
    localparam int COLOUR_W    = 24;
    localparam int CHAN_W      = 8;
    localparam int DUTY_W      = 16;
    localparam int LED_COUNT_W = 9;
    localparam int INDEX_W     = 8;
    localparam int KIND_W      = 2;
    localparam int BIT_W       = 5;
    localparam int BITS_PER_LED = 24;

    // Configuration port.
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = 2;

    localparam logic [REG_IDX_W-1:0] REG_LED_COUNT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DUTY_ZERO = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DUTY_ONE  = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_SET_PIXEL = 2'd0,
        KIND_FILL      = 2'd1,
        KIND_SHOW      = 2'd2,
        KIND_TICK      = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_COPY,
        ST_DRAIN,
        ST_TICK
    } state_t;

    typedef struct packed {
        logic [LED_COUNT_W-1:0] led_count;
        logic [DUTY_W-1:0]      duty_zero;
        logic [DUTY_W-1:0]      duty_one;
    } cfg_t;

    typedef struct packed {
        logic pix_write;
        logic fill_start;
        logic fill_write;
        logic show_start;
        logic copy_read;
        logic tick_emit;
        logic tick_close;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic idx_ok;
        logic n_zero;
        logic sweep_last;
        logic frame_more;
        logic out_blocked;
    } status_t;

endpackage

// ===== rtl/core/ledser_ram.sv =====
module ledser_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/ledser_regs.sv =====
module ledser_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ledser_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ledser_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ledser_pkg::APB_DATA_W-1:0] prdata,
    output logic                              pready,
    output ledser_pkg::cfg_t                  cfg
);

    ledser_pkg::cfg_t cfg_reg;
    ledser_pkg::cfg_t cfg_next;
    logic [ledser_pkg::REG_IDX_W-1:0] reg_idx;
    logic wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ledser_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                ledser_pkg::REG_LED_COUNT:
                    cfg_next.led_count = pwdata[ledser_pkg::LED_COUNT_W-1:0];
                ledser_pkg::REG_DUTY_ZERO:
                    cfg_next.duty_zero = pwdata[ledser_pkg::DUTY_W-1:0];
                ledser_pkg::REG_DUTY_ONE:
                    cfg_next.duty_one = pwdata[ledser_pkg::DUTY_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            ledser_pkg::REG_LED_COUNT:
                prdata = ledser_pkg::APB_DATA_W'(cfg_reg.led_count);
            ledser_pkg::REG_DUTY_ZERO:
                prdata = ledser_pkg::APB_DATA_W'(cfg_reg.duty_zero);
            ledser_pkg::REG_DUTY_ONE:
                prdata = ledser_pkg::APB_DATA_W'(cfg_reg.duty_one);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/ledser_ctrl.sv =====
module ledser_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [ledser_pkg::KIND_W-1:0] kind,
    input  ledser_pkg::status_t           status,
    output logic                          in_stall,
    output ledser_pkg::cmd_t              cmd
);

    ledser_pkg::state_t state_reg;
    ledser_pkg::state_t state_next;
    logic accept;

    // A tick may only enter when the output register will be free for its word.
    assign in_stall = (state_reg != ledser_pkg::ST_IDLE) ||
                      ((kind == ledser_pkg::KIND_TICK) && status.out_blocked);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ledser_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        ledser_pkg::KIND_SET_PIXEL:
                            state_next = ledser_pkg::ST_IDLE;
                        ledser_pkg::KIND_FILL:
                            if (!status.n_zero)
                            begin
                                state_next = ledser_pkg::ST_FILL;
                            end
                        ledser_pkg::KIND_SHOW:
                            if (!status.busy && !status.n_zero)
                            begin
                                state_next = ledser_pkg::ST_COPY;
                            end
                        ledser_pkg::KIND_TICK:
                            if (status.busy && status.frame_more)
                            begin
                                state_next = ledser_pkg::ST_TICK;
                            end
                    endcase
                end
            end
            ledser_pkg::ST_FILL:
                if (status.sweep_last)
                begin
                    state_next = ledser_pkg::ST_IDLE;
                end
            ledser_pkg::ST_COPY:
                if (status.sweep_last)
                begin
                    state_next = ledser_pkg::ST_DRAIN;
                end
            ledser_pkg::ST_DRAIN:
                state_next = ledser_pkg::ST_IDLE;
            ledser_pkg::ST_TICK:
                state_next = ledser_pkg::ST_IDLE;
            default:
                state_next = ledser_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ledser_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        ledser_pkg::KIND_SET_PIXEL:
                            cmd.pix_write = status.idx_ok;
                        ledser_pkg::KIND_FILL:
                            cmd.fill_start = !status.n_zero;
                        ledser_pkg::KIND_SHOW:
                            cmd.show_start = !status.busy;
                        ledser_pkg::KIND_TICK:
                        begin
                            cmd.tick_close = status.busy && !status.frame_more;
                        end
                    endcase
                end
            end
            ledser_pkg::ST_FILL:
                cmd.fill_write = 1'b1;
            ledser_pkg::ST_COPY:
                cmd.copy_read = 1'b1;
            ledser_pkg::ST_DRAIN:
                cmd = '0;
            ledser_pkg::ST_TICK:
                cmd.tick_emit = 1'b1;
            default:
                cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ledser_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/ledser_dp.sv =====
module ledser_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ledser_pkg::cmd_t               cmd,
    input  ledser_pkg::cfg_t               cfg,
    input  logic [ledser_pkg::INDEX_W-1:0] pixel_index,
    input  logic [ledser_pkg::CHAN_W-1:0]  red,
    input  logic [ledser_pkg::CHAN_W-1:0]  green,
    input  logic [ledser_pkg::CHAN_W-1:0]  blue,
    input  logic                           out_stall,
    output ledser_pkg::status_t            status,
    output logic                           out_valid,
    output logic [ledser_pkg::DUTY_W-1:0]  duty,
    output logic                           last_word
);

    localparam int ADDR_W   = ledser_pkg::ADDR_W;
    localparam int CNT_W    = ledser_pkg::CNT_W;
    localparam int COLOUR_W = ledser_pkg::COLOUR_W;
    localparam int BIT_W    = ledser_pkg::BIT_W;

    logic [CNT_W-1:0]    n_active;
    logic [COLOUR_W-1:0] colour_in;
    logic [ADDR_W-1:0]   pix_addr;
    logic [ADDR_W-1:0]   sweep_addr;
    logic [ADDR_W-1:0]   led_addr;
    logic [BIT_W-1:0]    bit_pos;
    logic                cur_bit;

    logic [CNT_W-1:0]    sweep_cnt_reg,  sweep_cnt_next;
    logic [CNT_W-1:0]    frame_leds_reg, frame_leds_next;
    logic [CNT_W-1:0]    led_ptr_reg,    led_ptr_next;
    logic [BIT_W-1:0]    bit_ptr_reg,    bit_ptr_next;
    logic                busy_reg,       busy_next;
    logic [ledser_pkg::MAX_LEDS-1:0] colour_vld_reg, colour_vld_next;
    logic [COLOUR_W-1:0] fill_colour_reg, fill_colour_next;
    logic                copy_pend_reg,  copy_pend_next;
    logic [ADDR_W-1:0]   copy_addr_reg,  copy_addr_next;
    logic                copy_vld_reg,   copy_vld_next;
    logic                out_valid_reg,  out_valid_next;
    logic [ledser_pkg::DUTY_W-1:0] duty_reg, duty_next;
    logic                last_reg,       last_next;

    logic                colour_we;
    logic [ADDR_W-1:0]   colour_waddr;
    logic [COLOUR_W-1:0] colour_wdata;
    logic [COLOUR_W-1:0] colour_rdata;
    logic [COLOUR_W-1:0] shadow_wdata;
    logic [COLOUR_W-1:0] shadow_rdata;

    // A count above the store depth behaves as the full depth.
    always_comb
    begin
        if (32'(cfg.led_count) > 32'(ledser_pkg::MAX_LEDS))
        begin
            n_active = CNT_W'(ledser_pkg::MAX_LEDS);
        end
        else
        begin
            n_active = CNT_W'(cfg.led_count);
        end
    end

    assign colour_in  = {green, red, blue};
    assign pix_addr   = ADDR_W'(pixel_index);
    assign sweep_addr = sweep_cnt_reg[ADDR_W-1:0];
    assign led_addr   = led_ptr_reg[ADDR_W-1:0];

    // Green byte first, each byte most significant bit first, so the slot
    // number counts down from the top of the packed colour word.
    assign bit_pos = BIT_W'(COLOUR_W - 1) - bit_ptr_reg;
    assign cur_bit = shadow_rdata[bit_pos];

    assign status.busy        = busy_reg;
    assign status.idx_ok      = 32'(pixel_index) < 32'(n_active);
    assign status.n_zero      = (n_active == '0);
    assign status.sweep_last  = ((sweep_cnt_reg + CNT_W'(1)) == n_active);
    assign status.frame_more  = (led_ptr_reg < frame_leds_reg);
    assign status.out_blocked = out_valid_reg && out_stall;

    always_comb
    begin
        sweep_cnt_next   = sweep_cnt_reg;
        frame_leds_next  = frame_leds_reg;
        led_ptr_next     = led_ptr_reg;
        bit_ptr_next     = bit_ptr_reg;
        busy_next        = busy_reg;
        colour_vld_next  = colour_vld_reg;
        fill_colour_next = fill_colour_reg;
        copy_pend_next   = cmd.copy_read;
        copy_addr_next   = sweep_addr;
        copy_vld_next    = colour_vld_reg[sweep_addr];
        out_valid_next   = out_valid_reg && out_stall;
        duty_next        = duty_reg;
        last_next        = last_reg;

        if (cmd.pix_write)
        begin
            colour_vld_next[pix_addr] = 1'b1;
        end

        if (cmd.fill_start)
        begin
            fill_colour_next = colour_in;
            sweep_cnt_next   = '0;
        end

        if (cmd.fill_write)
        begin
            colour_vld_next[sweep_addr] = 1'b1;
            sweep_cnt_next = sweep_cnt_reg + CNT_W'(1);
        end

        if (cmd.show_start)
        begin
            frame_leds_next = n_active;
            led_ptr_next    = '0;
            bit_ptr_next    = '0;
            busy_next       = 1'b1;
            sweep_cnt_next  = '0;
        end

        if (cmd.copy_read)
        begin
            sweep_cnt_next = sweep_cnt_reg + CNT_W'(1);
        end

        if (cmd.tick_emit)
        begin
            out_valid_next = 1'b1;
            duty_next      = cur_bit ? cfg.duty_one : cfg.duty_zero;
            last_next      = 1'b0;
            if (bit_ptr_reg == BIT_W'(ledser_pkg::BITS_PER_LED - 1))
            begin
                bit_ptr_next = '0;
                led_ptr_next = led_ptr_reg + CNT_W'(1);
            end
            else
            begin
                bit_ptr_next = bit_ptr_reg + BIT_W'(1);
            end
        end

        if (cmd.tick_close)
        begin
            out_valid_next = 1'b1;
            duty_next      = '0;
            last_next      = 1'b1;
            busy_next      = 1'b0;
            led_ptr_next   = '0;
            bit_ptr_next   = '0;
        end
    end

    assign colour_we    = cmd.pix_write || cmd.fill_write;
    assign colour_waddr = cmd.pix_write ? pix_addr : sweep_addr;
    assign colour_wdata = cmd.pix_write ? colour_in : fill_colour_reg;

    // An entry never written since reset reads as black.
    assign shadow_wdata = copy_vld_reg ? colour_rdata : '0;

    ledser_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (ledser_pkg::MAX_LEDS)
    ) u_colour_ram (
        .clk   (clk),
        .we    (colour_we),
        .waddr (colour_waddr),
        .wdata (colour_wdata),
        .raddr (sweep_addr),
        .rdata (colour_rdata)
    );

    ledser_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (ledser_pkg::MAX_LEDS)
    ) u_shadow_ram (
        .clk   (clk),
        .we    (copy_pend_reg),
        .waddr (copy_addr_reg),
        .wdata (shadow_wdata),
        .raddr (led_addr),
        .rdata (shadow_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg  <= '0;
            frame_leds_reg <= '0;
            led_ptr_reg    <= '0;
            bit_ptr_reg    <= '0;
            busy_reg       <= 1'b0;
            colour_vld_reg <= '0;
            copy_pend_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            sweep_cnt_reg  <= sweep_cnt_next;
            frame_leds_reg <= frame_leds_next;
            led_ptr_reg    <= led_ptr_next;
            bit_ptr_reg    <= bit_ptr_next;
            busy_reg       <= busy_next;
            colour_vld_reg <= colour_vld_next;
            copy_pend_reg  <= copy_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_colour_reg <= fill_colour_next;
        copy_addr_reg   <= copy_addr_next;
        copy_vld_reg    <= copy_vld_next;
        duty_reg        <= duty_next;
        last_reg        <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign duty      = duty_reg;
    assign last_word = last_reg;

endmodule

// ===== rtl/core/rgb_led_chain_serializer.sv =====
// Serialiser for a chain of single-wire RGB LEDs. Items on the input channel
// set one pixel, fill every pixel below the LED count, start a frame (show) or
// ask for the next duty word (tick); only a tick during a frame yields an item
// on the output channel: one duty word per colour bit, green, red then blue,
// most significant bit first, and a final zero word flagged by last_word.
// A set_pixel, an idle tick or a show during a frame is handled in the idle
// state. A tick for a data word during a frame passes through a tick state,
// which uses the registered read of the shadow store; the tick for the
// closing word does not. A tick is held off while the previous word still
// waits on the output. A fill walks the colour store one entry a cycle; a
// show copies the colour store into the shadow store one entry a cycle,
// then passes through a drain state, and makes no copy for an empty chain.
// No input item is taken during those walks. The colour store reads as black
// after reset without any clearing pass, and the duty registers are sampled
// at each word, so they may be changed between frames or between ticks.
module rgb_led_chain_serializer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ledser_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ledser_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ledser_pkg::APB_DATA_W-1:0] prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ledser_pkg::KIND_W-1:0]     kind,
    input  logic [ledser_pkg::INDEX_W-1:0]    pixel_index,
    input  logic [ledser_pkg::CHAN_W-1:0]     red,
    input  logic [ledser_pkg::CHAN_W-1:0]     green,
    input  logic [ledser_pkg::CHAN_W-1:0]     blue,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ledser_pkg::DUTY_W-1:0]     duty,
    output logic                              last_word
);

    ledser_pkg::cfg_t    cfg;
    ledser_pkg::cmd_t    cmd;
    ledser_pkg::status_t status;

    ledser_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ledser_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    ledser_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg         (cfg),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .out_stall   (out_stall),
        .status      (status),
        .out_valid   (out_valid),
        .duty        (duty),
        .last_word   (last_word)
    );

endmodule

// ===== test/tb_rgb_led_chain_serializer.sv =====
`timescale 1ns / 100ps

module tb_rgb_led_chain_serializer;

    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASE_ITEMS   = 90;
    localparam int PHASES        = 12;
    localparam int WHOLE_PHASE   = 6;
    localparam int PHASE_COUNT [PHASES] = '{2, 3, 1, 256, 4, 0, 16, 2, 8, 300, 3, 1};

    localparam logic [ledser_pkg::REG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [ledser_pkg::REG_IDX_W-1:0] NO_REG    = ledser_pkg::REG_LED_COUNT;
    localparam logic [ledser_pkg::REG_IDX_W-1:0] R_COUNT   = ledser_pkg::REG_LED_COUNT;
    localparam logic [ledser_pkg::REG_IDX_W-1:0] R_ZERO    = ledser_pkg::REG_DUTY_ZERO;
    localparam logic [ledser_pkg::REG_IDX_W-1:0] R_ONE     = ledser_pkg::REG_DUTY_ONE;
    localparam ledser_pkg::kind_t OP_SET  = ledser_pkg::KIND_SET_PIXEL;
    localparam ledser_pkg::kind_t OP_FILL = ledser_pkg::KIND_FILL;
    localparam ledser_pkg::kind_t OP_SHOW = ledser_pkg::KIND_SHOW;
    localparam ledser_pkg::kind_t OP_TICK = ledser_pkg::KIND_TICK;
    localparam bit ROW_ITEM = 1'b0;
    localparam bit ROW_REG  = 1'b1;

    typedef struct packed {
        ledser_pkg::kind_t              op;
        logic [ledser_pkg::INDEX_W-1:0] pix;
        logic [ledser_pkg::CHAN_W-1:0]  r;
        logic [ledser_pkg::CHAN_W-1:0]  g;
        logic [ledser_pkg::CHAN_W-1:0]  b;
    } stim_t;

    typedef struct packed {
        logic [ledser_pkg::DUTY_W-1:0] level;
        logic                          closing;
    } duty_word_t;

    typedef struct packed {
        bit                               is_reg;
        logic [ledser_pkg::REG_IDX_W-1:0] reg_sel;
        logic [15:0]                      reg_val;
        stim_t                            stim;
        bit                               typed;
        duty_word_t                       want;
    } row_t;

    localparam duty_word_t NO_WORD = '0;
    localparam stim_t NO_STIM = '{OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00};

    localparam row_t DIRECTED [22] = '{
        // An idle tick, then an empty chain whose show yields only the closing word.
        '{ROW_ITEM, NO_REG, 16'h0, '{OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_WORD},
        '{ROW_ITEM, NO_REG, 16'h0, '{OP_SHOW, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_WORD},
        '{ROW_ITEM, NO_REG, 16'h0, '{OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
          '{16'h0000, 1'b1}},
        '{ROW_ITEM, NO_REG, 16'h0, '{OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_WORD},
        // With no LEDs configured, pixel writes and fills change nothing.
        '{ROW_ITEM, NO_REG, 16'h0, '{OP_SET, 8'h00, 8'hFF, 8'hFF, 8'hFF}, 1'b0, NO_WORD},
        '{ROW_ITEM, NO_REG, 16'h0, '{OP_FILL, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0, NO_WORD},
        '{ROW_REG, R_COUNT, 16'h0001, NO_STIM, 1'b0, NO_WORD},
        '{ROW_REG, R_ZERO, 16'h0000, NO_STIM, 1'b0, NO_WORD},
        '{ROW_REG, R_ONE, 16'hFFFF, NO_STIM, 1'b0, NO_WORD},
        '{ROW_REG, REG_SPARE, 16'hFFFF, NO_STIM, 1'b0, NO_WORD},
        '{ROW_ITEM, NO_REG, 16'h0, '{OP_SET, 8'h00, 8'h00, 8'hFF, 8'h01}, 1'b0, NO_WORD},
        '{ROW_ITEM, NO_REG, 16'h0, '{OP_SET, 8'hFF, 8'hFF, 8'h00, 8'h00}, 1'b0, NO_WORD},
        '{ROW_ITEM, NO_REG, 16'h0, '{OP_SHOW, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_WORD},
        // Writes and a second show during the frame must not disturb it.
        '{ROW_ITEM, NO_REG, 16'h0, '{OP_SET, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_WORD},
        '{ROW_ITEM, NO_REG, 16'h0, '{OP_FILL, 8'h80, 8'hFF, 8'hFF, 8'hFF}, 1'b0, NO_WORD},
        '{ROW_ITEM, NO_REG, 16'h0, '{OP_SHOW, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_WORD},
        '{ROW_ITEM, NO_REG, 16'h0, '{OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
          '{16'hFFFF, 1'b0}},
        '{ROW_ITEM, NO_REG, 16'h0, '{OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
          '{16'hFFFF, 1'b0}},
        '{ROW_ITEM, NO_REG, 16'h0, '{OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_WORD},
        '{ROW_ITEM, NO_REG, 16'h0, '{OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_WORD},
        '{ROW_ITEM, NO_REG, 16'h0, '{OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_WORD},
        '{ROW_ITEM, NO_REG, 16'h0, '{OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NO_WORD}
    };

    logic                              clk         = 1'b0;
    logic                              rst_n       = 1'b0;
    logic                              psel        = 1'b0;
    logic                              penable     = 1'b0;
    logic                              pwrite      = 1'b0;
    logic [ledser_pkg::APB_ADDR_W-1:0] paddr       = '0;
    logic [ledser_pkg::APB_DATA_W-1:0] pwdata      = '0;
    logic [ledser_pkg::APB_DATA_W-1:0] prdata;
    logic                              pready;
    logic                              in_valid    = 1'b0;
    logic                              in_stall;
    ledser_pkg::kind_t                 kind        = ledser_pkg::KIND_SET_PIXEL;
    logic [ledser_pkg::INDEX_W-1:0]    pixel_index = '0;
    logic [ledser_pkg::CHAN_W-1:0]     red         = '0;
    logic [ledser_pkg::CHAN_W-1:0]     green       = '0;
    logic [ledser_pkg::CHAN_W-1:0]     blue        = '0;
    logic                              out_valid;
    logic                              out_stall   = 1'b0;
    logic [ledser_pkg::DUTY_W-1:0]     duty;
    logic                              last_word;

    // Predicted state of the chain.
    logic [ledser_pkg::COLOUR_W-1:0]    colour_mem [ledser_pkg::MAX_LEDS];
    logic [ledser_pkg::COLOUR_W-1:0]    frame_mem  [ledser_pkg::MAX_LEDS];
    bit                                 frame_busy  = 1'b0;
    int unsigned                        frame_led   = 0;
    int unsigned                        frame_bit   = 0;
    int unsigned                        frame_len   = 0;
    int unsigned                        frames_done = 0;
    logic [ledser_pkg::LED_COUNT_W-1:0] cfg_count   = '0;
    logic [ledser_pkg::DUTY_W-1:0]      cfg_zero    = '0;
    logic [ledser_pkg::DUTY_W-1:0]      cfg_one     = '0;

    duty_word_t  pending_words [$];
    duty_word_t  oldest_word;
    int unsigned mismatches     = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;

    rgb_led_chain_serializer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .duty        (duty),
        .last_word   (last_word)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < ledser_pkg::MAX_LEDS; i++)
        begin
            colour_mem[i] = '0;
            frame_mem[i]  = '0;
        end
    end

    // Applies one accepted item to the predicted chain. Returns whether the item
    // had any effect; a duty word, if one is due, comes back through next_word.
    function automatic bit advance_chain(input stim_t s, output bit produced,
                                         output duty_word_t next_word);
        int unsigned                     n;
        logic [ledser_pkg::COLOUR_W-1:0] grb;
        n         = (cfg_count > ledser_pkg::MAX_LEDS) ? ledser_pkg::MAX_LEDS : cfg_count;
        grb       = {s.g, s.r, s.b};
        produced  = 1'b0;
        next_word = '0;
        case (s.op)
            ledser_pkg::KIND_SET_PIXEL:
            begin
                if (s.pix < n)
                begin
                    colour_mem[s.pix] = grb;
                    return 1'b1;
                end
            end
            ledser_pkg::KIND_FILL:
            begin
                for (int i = 0; i < n; i++)
                    colour_mem[i] = grb;
                return n != 0;
            end
            ledser_pkg::KIND_SHOW:
            begin
                if (!frame_busy)
                begin
                    frame_mem  = colour_mem;
                    frame_len  = n;
                    frame_led  = 0;
                    frame_bit  = 0;
                    frame_busy = 1'b1;
                    return 1'b1;
                end
            end
            default:
            begin
                if (frame_busy)
                begin
                    produced = 1'b1;
                    if (frame_led < frame_len)
                    begin
                        // Green, red then blue, each most significant bit first.
                        next_word.level =
                            frame_mem[frame_led][ledser_pkg::COLOUR_W - 1 - frame_bit]
                            ? cfg_one : cfg_zero;
                        frame_bit++;
                        if (frame_bit == ledser_pkg::BITS_PER_LED)
                        begin
                            frame_bit = 0;
                            frame_led++;
                        end
                    end
                    else
                    begin
                        next_word.closing = 1'b1;
                        frame_busy = 1'b0;
                        frame_led  = 0;
                        frame_bit  = 0;
                        frames_done++;
                    end
                    return 1'b1;
                end
            end
        endcase
        return 1'b0;
    endfunction

    function automatic logic [ledser_pkg::CHAN_W-1:0] pick_level();
        case ($urandom_range(5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return ledser_pkg::CHAN_W'($urandom_range(255));
        endcase
    endfunction

    task automatic send_item(input stim_t s, input bit typed, input duty_word_t typed_word,
                             output bit effective);
        bit         produced;
        duty_word_t next_word;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= s.op;
        pixel_index <= s.pix;
        red         <= s.r;
        green       <= s.g;
        blue        <= s.b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        effective = advance_chain(s, produced, next_word);
        if (produced || typed)
            pending_words.push_back(typed ? typed_word : next_word);
    endtask

    task automatic drain_words();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    // A fill or a show leaves no word behind, so the block may still be walking
    // its store when the queue runs dry; give it time before touching registers.
    task automatic settle();
        drain_words();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [ledser_pkg::REG_IDX_W-1:0] sel,
                             input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {16'h0000, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (sel)
            ledser_pkg::REG_LED_COUNT: cfg_count = val[ledser_pkg::LED_COUNT_W-1:0];
            ledser_pkg::REG_DUTY_ZERO: cfg_zero  = val;
            ledser_pkg::REG_DUTY_ONE:  cfg_one   = val;
            default:                   ;
        endcase
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected duty word: duty %h last %b", duty, last_word);
                end
                else
                begin
                    oldest_word = pending_words.pop_front();
                    if (duty !== oldest_word.level || last_word !== oldest_word.closing)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("duty word mismatch: expected %h/%b, got %h/%b",
                                     oldest_word.level, oldest_word.closing, duty, last_word);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("rgb_led_chain_serializer test failed");
            $finish;
        end
    end

    initial
    begin
        stim_t       s;
        bit          eff;
        bit          whole_chain;
        int unsigned n;
        int unsigned pick;
        int unsigned closes_wanted;
        int unsigned useful;
        logic [15:0] d0;
        logic [15:0] d1;

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < $size(DIRECTED); k++)
        begin
            if (DIRECTED[k].is_reg)
            begin
                settle();
                write_reg(DIRECTED[k].reg_sel, DIRECTED[k].reg_val);
            end
            else
            begin
                send_item(DIRECTED[k].stim, DIRECTED[k].typed, DIRECTED[k].want, eff);
            end
        end

        // The first phase rewrites the duties while the directed frame is still
        // running, so the new values must show up on its remaining words.
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case ((p + p / 4) % 4)
                0:
                begin
                    d0 = 16'h0000;
                    d1 = 16'hFFFF;
                end
                1:
                begin
                    d0 = 16'hFFFF;
                    d1 = 16'h0000;
                end
                2:
                begin
                    d0 = 16'($urandom_range(16'hFFFF));
                    d1 = 16'($urandom_range(16'hFFFF));
                end
                default:
                begin
                    d0 = 16'($urandom_range(16'hFFFF));
                    d1 = d0;
                end
            endcase
            write_reg(ledser_pkg::REG_LED_COUNT, 16'(PHASE_COUNT[p]));
            write_reg(ledser_pkg::REG_DUTY_ZERO, d0);
            write_reg(ledser_pkg::REG_DUTY_ONE, d1);
            send_gap_pct   = (p % 4 == 1) ? 71 : (p % 4 == 3) ? 28 : 0;
            recv_stall_pct = (p % 4 == 2) ? 71 : (p % 4 == 3) ? 28 : 0;

            // One phase shows a longer chain and runs its frames out; elsewhere
            // only short chains are shown, and long ones just take writes and fills.
            n             = (cfg_count > ledser_pkg::MAX_LEDS) ? ledser_pkg::MAX_LEDS
                                                               : cfg_count;
            whole_chain   = (p == WHOLE_PHASE);
            closes_wanted = frames_done + (frame_busy ? 2 : 1);
            useful        = 0;
            while (whole_chain ? (frames_done < closes_wanted) : (useful < PHASE_ITEMS))
            begin
                if ($urandom_range(199) == 0 || (p == 1 && useful == PHASE_ITEMS / 2))
                    drain_words();
                s.r   = pick_level();
                s.g   = pick_level();
                s.b   = pick_level();
                s.pix = (n != 0 && $urandom_range(3) != 0)
                        ? ledser_pkg::INDEX_W'($urandom_range(n - 1))
                        : ledser_pkg::INDEX_W'($urandom_range(255));
                pick  = $urandom_range(99);
                if (frame_busy)
                begin
                    if (pick < 86)
                        s.op = ledser_pkg::KIND_TICK;
                    else if (pick < 91)
                        s.op = ledser_pkg::KIND_SET_PIXEL;
                    else if (pick < 95)
                        s.op = ledser_pkg::KIND_FILL;
                    else
                        s.op = ledser_pkg::KIND_SHOW;
                end
                else if (pick < 40 || pick >= 92)
                    s.op = ledser_pkg::KIND_SET_PIXEL;
                else if (pick < 52)
                    s.op = ledser_pkg::KIND_FILL;
                else if (pick < 82)
                    s.op = (n <= 8 || whole_chain) ? ledser_pkg::KIND_SHOW
                                                   : ledser_pkg::KIND_SET_PIXEL;
                else
                    s.op = ledser_pkg::KIND_TICK;
                send_item(s, 1'b0, NO_WORD, eff);
                useful += eff;
            end
        end

        drain_words();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (mismatches == 0 && pending_words.size() == 0)
            $display("rgb_led_chain_serializer test passed");
        else
            $display("rgb_led_chain_serializer test failed");
        $finish;
    end

endmodule
